### rtl/ctt_pkg.sv
// Shared types, command and error codes, and default sizes for the completion tag tracker.
package ctt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [2:0] CMD_ARM      = 3'd0;
  localparam logic [2:0] CMD_SUBMIT   = 3'd1;
  localparam logic [2:0] CMD_COMPLETE = 3'd2;
  localparam logic [2:0] CMD_DRAIN    = 3'd3;
  localparam logic [2:0] CMD_STOP     = 3'd4;
  localparam logic [2:0] CMD_JOIN     = 3'd5;
  localparam logic [2:0] CMD_CLOSE    = 3'd6;

  localparam logic [3:0] ERR_NONE           = 4'd0;
  localparam logic [3:0] ERR_OVERFLOW       = 4'd1;
  localparam logic [3:0] ERR_DUPLICATE      = 4'd2;
  localparam logic [3:0] ERR_GEN_MISMATCH   = 4'd3;
  localparam logic [3:0] ERR_NOT_ARMED      = 4'd4;
  localparam logic [3:0] ERR_BAD_STATE      = 4'd5;
  localparam logic [3:0] ERR_LAUNCH_FAIL    = 4'd6;
  localparam logic [3:0] ERR_AFTER_STOP     = 4'd7;
  localparam logic [3:0] ERR_CLOSE_ACTIVE   = 4'd8;
  localparam logic [3:0] ERR_CLOSE_RETAINED = 4'd9;
  localparam logic [3:0] ERR_CLOSE_UNJOINED = 4'd10;
  localparam logic [3:0] ERR_TABLE_FULL     = 4'd11;
  localparam logic [3:0] ERR_CLOSED         = 4'd12;
  localparam logic [3:0] ERR_JOIN_PENDING   = 4'd13;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] cookie;
    logic [63:0] gen_low;
    logic [63:0] gen_high;
    logic [9:0]  launch_error;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  tag_op;
    logic  drain_op;
  } job_t;

  typedef struct packed {
    logic [63:0] cookie;
    logic [63:0] gen_low;
    logic [63:0] gen_high;
    logic        submitted;
  } tag_ent_t;

  typedef struct packed {
    logic [63:0] cookie;
    logic [63:0] gen_low;
    logic [63:0] gen_high;
  } fifo_ent_t;

endpackage

### rtl/ctt_front.sv
// Front end: accepts command items, classifies them and queues them for the back end.
module ctt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ctt_pkg::item_t  push_item,
  output logic            full,
  input  logic            take,
  output logic            job_valid,
  output ctt_pkg::job_t   job
);

  ctt_pkg::job_t q_r [2];
  logic          wr_r;
  logic          rd_r;
  logic [1:0]    cnt_r;
  ctt_pkg::job_t in_job;
  logic          pop;

  always_comb begin
    in_job.item     = push_item;
    in_job.tag_op   = (push_item.cmd == ctt_pkg::CMD_ARM) ||
                      (push_item.cmd == ctt_pkg::CMD_SUBMIT);
    in_job.drain_op = (push_item.cmd == ctt_pkg::CMD_DRAIN);
  end

  assign full      = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_r];
  assign pop       = take && job_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/ctt_back.sv
// Back end: tag table search, completion queue, lifecycle checks and the fatal latch.
module ctt_back #(
  parameter int TABLE_DEPTH = ctt_pkg::TABLE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = ctt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  ctt_pkg::job_t   job,
  output logic            take,
  output logic            res_valid,
  output logic            res_status,
  output logic [3:0]      res_error_code,
  output logic            res_token_valid,
  output logic [63:0]     res_cookie,
  output logic [63:0]     res_gen_low,
  output logic [63:0]     res_gen_high,
  output logic [6:0]      res_queued_count,
  output logic [6:0]      res_live_count,
  output logic [6:0]      res_active_callbacks,
  output logic [3:0]      res_fatal_code,
  output logic [9:0]      res_fatal_detail,
  output logic            res_closed
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]          state_r;
  ctt_pkg::job_t       cur_r;

  ctt_pkg::tag_ent_t   tab_mem [TABLE_DEPTH];
  ctt_pkg::tag_ent_t   tab_rd_r;
  logic                tab_re;
  logic [AW-1:0]       tab_ra;
  logic                tab_we;
  logic [AW-1:0]       tab_wa;
  ctt_pkg::tag_ent_t   tab_wd;
  logic [TABLE_DEPTH-1:0] valid_r;

  ctt_pkg::fifo_ent_t  fifo_mem [QUEUE_DEPTH];
  ctt_pkg::fifo_ent_t  fifo_rd_r;
  logic                fifo_re;
  logic                fifo_we;

  logic [CW-1:0]       scan_a_r;
  logic                chk_r;
  logic [AW-1:0]       chk_idx_r;
  logic                found_r;
  logic [AW-1:0]       ent_idx_r;
  logic [63:0]         ent_gl_r;
  logic [63:0]         ent_gh_r;
  logic                ent_sub_r;
  logic                free_ok_r;
  logic [AW-1:0]       free_idx_r;
  logic [63:0]         key;
  logic                hit;

  logic [PW-1:0]       head_r, head_nxt;
  logic [PW-1:0]       tail_r, tail_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic [CW-1:0]       active_r, active_nxt;
  logic                open_r, open_nxt;
  logic                closed_r, closed_nxt;
  logic                joined_r, joined_nxt;
  logic                ever_r, ever_nxt;
  logic [3:0]          fat_r, fat_nxt;
  logic [9:0]          fdet_r, fdet_nxt;
  logic [63:0]         fc_r, fc_nxt;
  logic [63:0]         fgl_r, fgl_nxt;
  logic [63:0]         fgh_r, fgh_nxt;

  logic [3:0]          err;
  logic                tok;
  logic                lat_req;
  logic [3:0]          lat_code;
  logic [9:0]          lat_det;
  logic [63:0]         lat_c, lat_gl, lat_gh;
  logic                vset, vclr;
  logic [AW-1:0]       vidx;
  logic                need_scan;
  logic                need_fifo;
  ctt_pkg::item_t      it;

  assign it   = cur_r.item;
  assign take = (state_r == S_IDLE) && job_valid;
  assign key  = cur_r.drain_op ? fifo_rd_r.cookie : it.cookie;
  assign hit  = chk_r && valid_r[chk_idx_r] && (tab_rd_r.cookie == key);

  assign need_fifo = job.drain_op && !closed_r && (fill_r != '0);
  assign need_scan = (job.tag_op && (fat_r == ctt_pkg::ERR_NONE) && open_r && !closed_r) ||
                     need_fifo;
  assign fifo_re   = take && need_fifo;

  assign tab_re = (state_r == S_SCAN) && !hit && (scan_a_r < CW'(TABLE_DEPTH));
  assign tab_ra = scan_a_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (tab_re) begin
      tab_rd_r <= tab_mem[tab_ra];
    end
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_re) begin
      fifo_rd_r <= fifo_mem[head_r];
    end
    if (fifo_we) begin
      fifo_mem[tail_r] <= '{cookie: it.cookie, gen_low: it.gen_low, gen_high: it.gen_high};
    end
  end

  always_comb begin
    err       = ctt_pkg::ERR_NONE;
    tok       = 1'b0;
    lat_req   = 1'b0;
    lat_code  = ctt_pkg::ERR_NONE;
    lat_det   = '0;
    lat_c     = '0;
    lat_gl    = '0;
    lat_gh    = '0;
    tab_we    = 1'b0;
    tab_wa    = ent_idx_r;
    tab_wd    = '{cookie: it.cookie, gen_low: it.gen_low, gen_high: it.gen_high,
                  submitted: 1'b0};
    vset      = 1'b0;
    vclr      = 1'b0;
    vidx      = ent_idx_r;
    fifo_we   = 1'b0;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    live_nxt  = live_r;
    active_nxt = active_r;
    open_nxt  = open_r;
    closed_nxt = closed_r;
    joined_nxt = joined_r;
    ever_nxt  = ever_r;
    if (state_r == S_EXEC) begin
      case (it.cmd)
        ctt_pkg::CMD_ARM, ctt_pkg::CMD_SUBMIT: begin
          if (fat_r != ctt_pkg::ERR_NONE) begin
            err = fat_r;
          end else if (!open_r || closed_r) begin
            err = ctt_pkg::ERR_AFTER_STOP;
          end else if (it.cmd == ctt_pkg::CMD_ARM) begin
            if (found_r) begin
              err = (ent_gl_r == it.gen_low && ent_gh_r == it.gen_high) ?
                    ctt_pkg::ERR_DUPLICATE : ctt_pkg::ERR_GEN_MISMATCH;
            end else if (!free_ok_r) begin
              err = ctt_pkg::ERR_TABLE_FULL;
            end else begin
              tab_we   = 1'b1;
              tab_wa   = free_idx_r;
              vset     = 1'b1;
              vidx     = free_idx_r;
              live_nxt = live_r + 1'b1;
            end
          end else begin
            if (!found_r) begin
              err = ctt_pkg::ERR_NOT_ARMED;
            end else if (ent_gl_r != it.gen_low || ent_gh_r != it.gen_high) begin
              err = ctt_pkg::ERR_GEN_MISMATCH;
            end else if (ent_sub_r) begin
              err = ctt_pkg::ERR_BAD_STATE;
            end else begin
              tab_we           = 1'b1;
              tab_wd.submitted = 1'b1;
              joined_nxt       = 1'b0;
              if (it.launch_error != '0) begin
                err      = ctt_pkg::ERR_LAUNCH_FAIL;
                lat_req  = 1'b1;
                lat_code = ctt_pkg::ERR_LAUNCH_FAIL;
                lat_det  = it.launch_error;
                lat_c    = it.cookie;
                lat_gl   = it.gen_low;
                lat_gh   = it.gen_high;
              end else begin
                if (active_r < CW'(TABLE_DEPTH)) begin
                  active_nxt = active_r + 1'b1;
                end
                ever_nxt = 1'b1;
              end
            end
          end
        end
        ctt_pkg::CMD_COMPLETE: begin
          if (fill_r >= FW'(QUEUE_DEPTH)) begin
            err = ctt_pkg::ERR_OVERFLOW;
          end else begin
            fifo_we  = 1'b1;
            tail_nxt = (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
          if (active_r != '0) begin
            active_nxt = active_r - 1'b1;
          end
        end
        ctt_pkg::CMD_DRAIN: begin
          if (closed_r) begin
            err = ctt_pkg::ERR_CLOSED;
          end else if (fill_r != '0) begin
            head_nxt = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            fill_nxt = fill_r - 1'b1;
            if (!found_r) begin
              err = ctt_pkg::ERR_BAD_STATE;
            end else if (ent_gl_r != fifo_rd_r.gen_low || ent_gh_r != fifo_rd_r.gen_high) begin
              err = ctt_pkg::ERR_GEN_MISMATCH;
            end else if (!ent_sub_r) begin
              err = ctt_pkg::ERR_BAD_STATE;
            end else begin
              vclr     = 1'b1;
              live_nxt = live_r - 1'b1;
              tok      = 1'b1;
            end
            if (err != ctt_pkg::ERR_NONE) begin
              lat_req  = 1'b1;
              lat_code = err;
              lat_c    = fifo_rd_r.cookie;
              lat_gl   = fifo_rd_r.gen_low;
              lat_gh   = fifo_rd_r.gen_high;
            end
          end
        end
        ctt_pkg::CMD_STOP: begin
          open_nxt = 1'b0;
        end
        ctt_pkg::CMD_JOIN: begin
          open_nxt = 1'b0;
          if (active_r != '0) begin
            err = ctt_pkg::ERR_JOIN_PENDING;
          end else begin
            joined_nxt = 1'b1;
          end
        end
        ctt_pkg::CMD_CLOSE: begin
          open_nxt = 1'b0;
          if (!closed_r) begin
            if (active_r != '0) begin
              err = ctt_pkg::ERR_CLOSE_ACTIVE;
            end else if (fill_r != '0 || live_r != '0) begin
              err = ctt_pkg::ERR_CLOSE_RETAINED;
            end else if (ever_r && !joined_r) begin
              err = ctt_pkg::ERR_CLOSE_UNJOINED;
            end
            if (err != ctt_pkg::ERR_NONE) begin
              lat_req  = 1'b1;
              lat_code = err;
            end else if (fat_r != ctt_pkg::ERR_NONE) begin
              err = fat_r;
            end else begin
              closed_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if (err != ctt_pkg::ERR_NONE && !lat_req &&
          (it.cmd == ctt_pkg::CMD_ARM || it.cmd == ctt_pkg::CMD_SUBMIT ||
           it.cmd == ctt_pkg::CMD_COMPLETE)) begin
        lat_req  = 1'b1;
        lat_code = err;
        lat_c    = it.cookie;
        lat_gl   = it.gen_low;
        lat_gh   = it.gen_high;
      end
    end
    if (lat_req && fat_r == ctt_pkg::ERR_NONE) begin
      fat_nxt  = lat_code;
      fdet_nxt = lat_det;
      fc_nxt   = lat_c;
      fgl_nxt  = lat_gl;
      fgh_nxt  = lat_gh;
    end else begin
      fat_nxt  = fat_r;
      fdet_nxt = fdet_r;
      fc_nxt   = fc_r;
      fgl_nxt  = fgl_r;
      fgh_nxt  = fgh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && take) begin
      cur_r <= job;
    end
    if (state_r == S_SCAN) begin
      chk_idx_r <= tab_ra;
      if (hit) begin
        ent_idx_r <= chk_idx_r;
        ent_gl_r  <= tab_rd_r.gen_low;
        ent_gh_r  <= tab_rd_r.gen_high;
        ent_sub_r <= tab_rd_r.submitted;
      end
      if (tab_re && !free_ok_r && !valid_r[tab_ra]) begin
        free_idx_r <= tab_ra;
      end
    end
    if (state_r == S_EXEC) begin
      res_status           <= (err != ctt_pkg::ERR_NONE);
      res_error_code       <= err;
      res_token_valid      <= tok;
      res_cookie           <= (err != ctt_pkg::ERR_NONE) ? fc_nxt :
                              (tok ? fifo_rd_r.cookie : '0);
      res_gen_low          <= (err != ctt_pkg::ERR_NONE) ? fgl_nxt :
                              (tok ? fifo_rd_r.gen_low : '0);
      res_gen_high         <= (err != ctt_pkg::ERR_NONE) ? fgh_nxt :
                              (tok ? fifo_rd_r.gen_high : '0);
      res_queued_count     <= 7'(fill_nxt);
      res_live_count       <= 7'(live_nxt);
      res_active_callbacks <= 7'(active_nxt);
      res_fatal_code       <= fat_nxt;
      res_fatal_detail     <= fdet_nxt;
      res_closed           <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_valid <= 1'b0;
      scan_a_r  <= '0;
      chk_r     <= 1'b0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      valid_r   <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      live_r    <= '0;
      active_r  <= '0;
      open_r    <= 1'b1;
      closed_r  <= 1'b0;
      joined_r  <= 1'b0;
      ever_r    <= 1'b0;
      fat_r     <= '0;
      fdet_r    <= '0;
      fc_r      <= '0;
      fgl_r     <= '0;
      fgh_r     <= '0;
    end else begin
      res_valid <= (state_r == S_EXEC);
      case (state_r)
        S_IDLE: begin
          if (take) begin
            scan_a_r  <= '0;
            chk_r     <= 1'b0;
            found_r   <= 1'b0;
            free_ok_r <= 1'b0;
            state_r   <= need_scan ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found_r <= 1'b1;
            chk_r   <= 1'b0;
            state_r <= S_EXEC;
          end else begin
            chk_r <= tab_re;
            if (tab_re) begin
              scan_a_r <= scan_a_r + 1'b1;
              if (!valid_r[tab_ra]) begin
                free_ok_r <= 1'b1;
              end
            end else if (!chk_r) begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          state_r  <= S_IDLE;
          head_r   <= head_nxt;
          tail_r   <= tail_nxt;
          fill_r   <= fill_nxt;
          live_r   <= live_nxt;
          active_r <= active_nxt;
          open_r   <= open_nxt;
          closed_r <= closed_nxt;
          joined_r <= joined_nxt;
          ever_r   <= ever_nxt;
          fat_r    <= fat_nxt;
          fdet_r   <= fdet_nxt;
          fc_r     <= fc_nxt;
          fgl_r    <= fgl_nxt;
          fgh_r    <= fgh_nxt;
          if (vset) begin
            valid_r[vidx] <= 1'b1;
          end
          if (vclr) begin
            valid_r[vidx] <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/completion_tag_tracker_top.sv
// Top level of the completion tag tracker: front queue, back end and port wiring.
// An accepted item waits in the front queue until the back end is free, then runs a table search
// if it needs one and an execute step whose result is registered.
// The back end takes a new item only once it is done with the last; the table search is the
// long case, one entry per cycle, and a two-entry queue takes items while busy is low.
// Results cannot be held off; synchronous active-low reset clears all control state.
module completion_tag_tracker_top #(
  parameter int TABLE_DEPTH = ctt_pkg::TABLE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = ctt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [63:0] in_cookie,
  input  logic [63:0] in_gen_low,
  input  logic [63:0] in_gen_high,
  input  logic [9:0]  in_launch_error,
  output logic        out_valid,
  output logic        out_status,
  output logic [3:0]  out_error_code,
  output logic        out_token_valid,
  output logic [63:0] out_cookie,
  output logic [63:0] out_gen_low,
  output logic [63:0] out_gen_high,
  output logic [6:0]  out_queued_count,
  output logic [6:0]  out_live_count,
  output logic [6:0]  out_active_callbacks,
  output logic [3:0]  out_fatal_code,
  output logic [9:0]  out_fatal_detail,
  output logic        out_closed
);

  ctt_pkg::item_t in_item;
  ctt_pkg::job_t  job;
  logic           job_valid;
  logic           take;
  logic           push;

  assign in_item = '{cmd: in_cmd, cookie: in_cookie, gen_low: in_gen_low,
                     gen_high: in_gen_high, launch_error: in_launch_error};
  assign push    = start && !busy;

  ctt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .full      (busy),
    .take      (take),
    .job_valid (job_valid),
    .job       (job)
  );

  ctt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .job_valid            (job_valid),
    .job                  (job),
    .take                 (take),
    .res_valid            (out_valid),
    .res_status           (out_status),
    .res_error_code       (out_error_code),
    .res_token_valid      (out_token_valid),
    .res_cookie           (out_cookie),
    .res_gen_low          (out_gen_low),
    .res_gen_high         (out_gen_high),
    .res_queued_count     (out_queued_count),
    .res_live_count       (out_live_count),
    .res_active_callbacks (out_active_callbacks),
    .res_fatal_code       (out_fatal_code),
    .res_fatal_detail     (out_fatal_detail),
    .res_closed           (out_closed)
  );

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results in consecutive cycles");

  a_token_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_valid) |-> !out_status) else $error("token with failure");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == (out_error_code != ctt_pkg::ERR_NONE)))
    else $error("status and error code disagree");

  a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fatal_code != ctt_pkg::ERR_NONE) |=> $stable(out_fatal_code))
    else $error("fatal code replaced");

endmodule

### test/completion_tag_tracker_top_tb.sv
// Self-checking testbench for the completion tag tracker: tag lifecycle, FIFO and fatal latch.
module completion_tag_tracker_top_tb;

  localparam int TDEPTH = ctt_pkg::TABLE_DEPTH_DEF;
  localparam int QDEPTH = ctt_pkg::QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [63:0] cookie;
    logic [63:0] gl;
    logic [63:0] gh;
  } tag_t;

  typedef struct {
    logic        status;
    logic [3:0]  err;
    logic        tok;
    logic [63:0] cookie;
    logic [63:0] gl;
    logic [63:0] gh;
    logic [6:0]  queued;
    logic [6:0]  live;
    logic [6:0]  active;
    logic [3:0]  fcode;
    logic [9:0]  fdetail;
    logic        closed;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [63:0] in_cookie = '0;
  logic [63:0] in_gen_low = '0;
  logic [63:0] in_gen_high = '0;
  logic [9:0]  in_launch_error = '0;
  logic        out_valid, out_status, out_token_valid, out_closed;
  logic [3:0]  out_error_code, out_fatal_code;
  logic [63:0] out_cookie, out_gen_low, out_gen_high;
  logic [6:0]  out_queued_count, out_live_count, out_active_callbacks;
  logic [9:0]  out_fatal_detail;

  completion_tag_tracker_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_cookie(in_cookie), .in_gen_low(in_gen_low),
    .in_gen_high(in_gen_high), .in_launch_error(in_launch_error),
    .out_valid(out_valid), .out_status(out_status), .out_error_code(out_error_code),
    .out_token_valid(out_token_valid), .out_cookie(out_cookie),
    .out_gen_low(out_gen_low), .out_gen_high(out_gen_high),
    .out_queued_count(out_queued_count), .out_live_count(out_live_count),
    .out_active_callbacks(out_active_callbacks), .out_fatal_code(out_fatal_code),
    .out_fatal_detail(out_fatal_detail), .out_closed(out_closed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the tracker state.
  logic        sh_valid [TDEPTH];
  tag_t        sh_tag [TDEPTH];
  logic        sh_sub [TDEPTH];
  tag_t        sh_fifo [QDEPTH];
  int          sh_head, sh_tail, sh_fill, sh_live, sh_active;
  logic        sh_open, sh_closed, sh_joined, sh_ever;
  logic [3:0]  sh_fcode;
  logic [9:0]  sh_fdetail;
  tag_t        sh_ftag;

  outcome_t    pending_results[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          gap_pct = 0;
  int          idle_cycles = 0;

  // Stimulus-side bookkeeping of well-formed tags.
  tag_t        armed_tags[$];
  tag_t        launched_tags[$];
  int          queued_tags = 0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic tag_t fresh_tag();
    tag_t t;
    t.cookie = rand64();
    t.gl = rand64();
    t.gh = rand64();
    return t;
  endfunction

  function automatic int lookup_tag(logic [63:0] c);
    for (int i = 0; i < TDEPTH; i++)
      if (sh_valid[i] && sh_tag[i].cookie == c) return i;
    return -1;
  endfunction

  function automatic void latch_first(logic [3:0] code, logic [9:0] detail, tag_t t);
    if (sh_fcode != ctt_pkg::ERR_NONE) return;
    sh_fcode = code;
    sh_fdetail = detail;
    sh_ftag = t;
  endfunction

  function automatic outcome_t predict_tracker(logic [2:0] cmd, tag_t t, logic [9:0] lerr);
    outcome_t o;
    logic [3:0] err;
    tag_t popped, zero_tag;
    int idx;
    err = ctt_pkg::ERR_NONE;
    zero_tag = '{64'd0, 64'd0, 64'd0};
    o = '{default: '0};
    case (cmd)
      ctt_pkg::CMD_ARM, ctt_pkg::CMD_SUBMIT: begin
        idx = lookup_tag(t.cookie);
        if (sh_fcode != ctt_pkg::ERR_NONE) err = sh_fcode;
        else if (!sh_open || sh_closed) err = ctt_pkg::ERR_AFTER_STOP;
        else if (cmd == ctt_pkg::CMD_ARM) begin
          if (idx >= 0) begin
            err = (sh_tag[idx].gl == t.gl && sh_tag[idx].gh == t.gh) ?
                  ctt_pkg::ERR_DUPLICATE : ctt_pkg::ERR_GEN_MISMATCH;
          end else begin
            for (int i = 0; i < TDEPTH; i++)
              if (!sh_valid[i]) begin
                idx = i;
                break;
              end
            if (idx < 0) err = ctt_pkg::ERR_TABLE_FULL;
            else begin
              sh_valid[idx] = 1'b1;
              sh_tag[idx] = t;
              sh_sub[idx] = 1'b0;
              sh_live++;
            end
          end
        end else begin
          if (idx < 0) err = ctt_pkg::ERR_NOT_ARMED;
          else if (sh_tag[idx].gl != t.gl || sh_tag[idx].gh != t.gh)
            err = ctt_pkg::ERR_GEN_MISMATCH;
          else if (sh_sub[idx]) err = ctt_pkg::ERR_BAD_STATE;
          else begin
            sh_sub[idx] = 1'b1;
            sh_joined = 1'b0;
            if (lerr != 0) begin
              latch_first(ctt_pkg::ERR_LAUNCH_FAIL, lerr, t);
              err = ctt_pkg::ERR_LAUNCH_FAIL;
            end else begin
              if (sh_active < TDEPTH) sh_active++;
              sh_ever = 1'b1;
            end
          end
        end
      end
      ctt_pkg::CMD_COMPLETE: begin
        if (sh_fill >= QDEPTH) err = ctt_pkg::ERR_OVERFLOW;
        else begin
          sh_fifo[sh_tail] = t;
          sh_tail = (sh_tail + 1) % QDEPTH;
          sh_fill++;
        end
        if (sh_active > 0) sh_active--;
      end
      ctt_pkg::CMD_DRAIN: begin
        if (sh_closed) err = ctt_pkg::ERR_CLOSED;
        else if (sh_fill != 0) begin
          popped = sh_fifo[sh_head];
          sh_head = (sh_head + 1) % QDEPTH;
          sh_fill--;
          idx = lookup_tag(popped.cookie);
          if (idx < 0) err = ctt_pkg::ERR_BAD_STATE;
          else if (sh_tag[idx].gl != popped.gl || sh_tag[idx].gh != popped.gh)
            err = ctt_pkg::ERR_GEN_MISMATCH;
          else if (!sh_sub[idx]) err = ctt_pkg::ERR_BAD_STATE;
          else begin
            sh_valid[idx] = 1'b0;
            sh_live--;
            o.tok = 1'b1;
            o.cookie = popped.cookie;
            o.gl = popped.gl;
            o.gh = popped.gh;
          end
          if (err != ctt_pkg::ERR_NONE) latch_first(err, 10'd0, popped);
        end
      end
      ctt_pkg::CMD_STOP: sh_open = 1'b0;
      ctt_pkg::CMD_JOIN: begin
        sh_open = 1'b0;
        if (sh_active != 0) err = ctt_pkg::ERR_JOIN_PENDING;
        else sh_joined = 1'b1;
      end
      ctt_pkg::CMD_CLOSE: begin
        sh_open = 1'b0;
        if (!sh_closed) begin
          if (sh_active != 0) err = ctt_pkg::ERR_CLOSE_ACTIVE;
          else if (sh_fill != 0 || sh_live != 0) err = ctt_pkg::ERR_CLOSE_RETAINED;
          else if (sh_ever && !sh_joined) err = ctt_pkg::ERR_CLOSE_UNJOINED;
          if (err != ctt_pkg::ERR_NONE) latch_first(err, 10'd0, zero_tag);
          else if (sh_fcode != ctt_pkg::ERR_NONE) err = sh_fcode;
          else sh_closed = 1'b1;
        end
      end
      default: ;
    endcase
    if (err != ctt_pkg::ERR_NONE && (cmd == ctt_pkg::CMD_ARM || cmd == ctt_pkg::CMD_SUBMIT ||
        cmd == ctt_pkg::CMD_COMPLETE))
      latch_first(err, 10'd0, t);
    if (err != ctt_pkg::ERR_NONE) begin
      o.cookie = sh_ftag.cookie;
      o.gl = sh_ftag.gl;
      o.gh = sh_ftag.gh;
    end
    o.status = (err != ctt_pkg::ERR_NONE);
    o.err = err;
    o.queued = sh_fill[6:0];
    o.live = sh_live[6:0];
    o.active = sh_active[6:0];
    o.fcode = sh_fcode;
    o.fdetail = sh_fdetail;
    o.closed = sh_closed;
    return o;
  endfunction

  task automatic send_item(logic [2:0] cmd, tag_t t, logic [9:0] lerr);
    outcome_t exp_o;
    in_cmd <= cmd;
    in_cookie <= t.cookie;
    in_gen_low <= t.gl;
    in_gen_high <= t.gh;
    in_launch_error <= lerr;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_o = predict_tracker(cmd, t, lerr);
    pending_results = {pending_results, exp_o};
    items_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      outcome_t e;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual error_code %0d",
                 $realtime, out_error_code);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if ({out_status, out_error_code, out_token_valid, out_cookie, out_gen_low,
             out_gen_high, out_queued_count, out_live_count, out_active_callbacks,
             out_fatal_code, out_fatal_detail, out_closed} !==
            {e.status, e.err, e.tok, e.cookie, e.gl, e.gh, e.queued, e.live, e.active,
             e.fcode, e.fdetail, e.closed}) begin
          $display("%0t: mismatch expected st=%0d err=%0d tok=%0d c=%h gl=%h gh=%h",
                   $realtime, e.status, e.err, e.tok, e.cookie, e.gl, e.gh);
          $display("%0t:   expected q=%0d live=%0d act=%0d fc=%0d fd=%0d closed=%0d",
                   $realtime, e.queued, e.live, e.active, e.fcode, e.fdetail, e.closed);
          $display("%0t:   actual st=%0d err=%0d tok=%0d c=%h gl=%h gh=%h", $realtime,
                   out_status, out_error_code, out_token_valid, out_cookie, out_gen_low,
                   out_gen_high);
          $display("%0t:   actual q=%0d live=%0d act=%0d fc=%0d fd=%0d closed=%0d",
                   $realtime, out_queued_count, out_live_count, out_active_callbacks,
                   out_fatal_code, out_fatal_detail, out_closed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("completion_tag_tracker_top verification failed");
      $finish;
    end
  end

  task automatic test_directed_flow();
    tag_t lo, hi;
    lo = '{64'd0, 64'd0, 64'd0};
    hi = '{'1, '1, '1};
    send_item(ctt_pkg::CMD_DRAIN, lo, 10'd0);
    send_item(ctt_pkg::CMD_ARM, lo, 10'd0);
    send_item(ctt_pkg::CMD_ARM, hi, '1);
    send_item(ctt_pkg::CMD_SUBMIT, lo, 10'd0);
    send_item(ctt_pkg::CMD_SUBMIT, hi, 10'd0);
    send_item(ctt_pkg::CMD_COMPLETE, hi, 10'd0);
    send_item(ctt_pkg::CMD_COMPLETE, lo, 10'd0);
    send_item(3'd7, hi, '1);
    send_item(ctt_pkg::CMD_DRAIN, lo, 10'd0);
    send_item(ctt_pkg::CMD_DRAIN, lo, 10'd0);
    send_item(ctt_pkg::CMD_DRAIN, lo, 10'd0);
  endtask

  // Well-formed lifecycles with random tag content; nothing here raises a fatal.
  task automatic test_tag_lifecycles(int count);
    tag_t t;
    int r, k;
    for (int n = 0; n < count; n++) begin
      gap_pct = (n / 100) % 4 == 1 ? 61 : ((n / 100) % 4 == 3 ? 18 : 0);
      r = $urandom_range(99);
      if (r < 30 && sh_live < TDEPTH - 2) begin
        t = fresh_tag();
        armed_tags = {armed_tags, t};
        send_item(ctt_pkg::CMD_ARM, t, 10'd0);
      end else if (r < 55 && armed_tags.size() > 0) begin
        k = $urandom_range(armed_tags.size() - 1);
        t = armed_tags[k];
        armed_tags.delete(k);
        launched_tags = {launched_tags, t};
        send_item(ctt_pkg::CMD_SUBMIT, t, 10'd0);
      end else if (r < 80 && launched_tags.size() > 0 && queued_tags < QDEPTH) begin
        k = $urandom_range(launched_tags.size() - 1);
        t = launched_tags[k];
        launched_tags.delete(k);
        queued_tags++;
        send_item(ctt_pkg::CMD_COMPLETE, t, 10'($urandom_range(1023)));
      end else begin
        if (queued_tags > 0) queued_tags--;
        send_item(ctt_pkg::CMD_DRAIN, fresh_tag(), 10'($urandom_range(1023)));
      end
    end
  endtask

  task automatic test_launch_failure();
    tag_t t;
    gap_pct = 18;
    t = fresh_tag();
    send_item(ctt_pkg::CMD_ARM, t, 10'd0);
    send_item(ctt_pkg::CMD_SUBMIT, t, 10'($urandom_range(1023, 1)));
    send_item(ctt_pkg::CMD_ARM, fresh_tag(), 10'd0);
    send_item(ctt_pkg::CMD_SUBMIT, t, 10'd0);
  endtask

  task automatic test_queue_overflow();
    gap_pct = 0;
    for (int n = 0; n < QDEPTH + 3; n++)
      send_item(ctt_pkg::CMD_COMPLETE, fresh_tag(), 10'd0);
  endtask

  // Random commands of every kind, tags sometimes reused, after the fatal has latched.
  task automatic test_noise_and_shutdown(int count);
    tag_t t;
    gap_pct = 61;
    for (int n = 0; n < count; n++) begin
      t = fresh_tag();
      if (launched_tags.size() > 0 && $urandom_range(1)) begin
        t = launched_tags[$urandom_range(launched_tags.size() - 1)];
        if ($urandom_range(3) == 0) t.gh = rand64();
      end
      send_item(3'($urandom_range(7)), t, 10'($urandom_range(1023)));
    end
    send_item(ctt_pkg::CMD_JOIN, t, 10'd0);
    send_item(ctt_pkg::CMD_STOP, t, 10'd0);
    send_item(ctt_pkg::CMD_CLOSE, t, 10'd0);
    send_item(ctt_pkg::CMD_CLOSE, t, 10'd0);
    send_item(ctt_pkg::CMD_DRAIN, t, 10'd0);
  endtask

  initial begin
    for (int i = 0; i < TDEPTH; i++) sh_valid[i] = 1'b0;
    sh_head = 0; sh_tail = 0; sh_fill = 0; sh_live = 0; sh_active = 0;
    sh_open = 1'b1; sh_closed = 1'b0; sh_joined = 1'b0; sh_ever = 1'b0;
    sh_fcode = ctt_pkg::ERR_NONE; sh_fdetail = '0; sh_ftag = '{64'd0, 64'd0, 64'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_flow();
    test_tag_lifecycles(400);
    test_launch_failure();
    test_queue_overflow();
    test_noise_and_shutdown(80);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TDEPTH + 10) @(posedge clk);
    $display("Sent %0d items and checked %0d results across tag lifecycles,", items_sent,
             results_seen);
    $display("launch failure, queue overflow, drain checks and shutdown commands.");
    if (errors == 0) begin
      $display("completion_tag_tracker_top verification clean");
    end else begin
      $display("completion_tag_tracker_top verification failed");
    end
    $finish;
  end

endmodule
